// File: sv/cle_pkg.sv
`default_nettype none

package cle_pkg;

  // fixed field widths of the stream items
  localparam int WORD_W   = 64;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  // command codes carried in the input tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_RIGHT     = 3'd1,
    REQ_LEFT      = 3'd2,
    REQ_BACKSPACE = 3'd3,
    REQ_DELETE    = 3'd4,
    REQ_READ      = 3'd5
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_EDGE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // controller to datapath phase strobes
  typedef struct packed {
    logic load;
    logic rd1;
    logic rd2;
    logic wr1;
    logic wr2;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic skip_wr1;
  } dp_stat_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] read_word;
    logic              read_valid;
    logic              read_last;
  } res_t;

endpackage

`default_nettype wire

// File: sv/cle_ctrl.sv
`default_nettype none

module cle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              slot_free,
  input  wire cle_pkg::dp_stat_t stat,
  output cle_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD1  = 5'b00010,
    S_RD2  = 5'b00100,
    S_WR1  = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // a new item is taken when idle or when the last phase retires
  always_comb begin
    in_ready = (state_r == S_IDLE) || ((state_r == S_WR2) && slot_free);
    cmd.load = in_valid && in_ready;
    cmd.rd1  = (state_r == S_RD1);
    cmd.rd2  = (state_r == S_RD2);
    cmd.wr1  = (state_r == S_WR1);
    cmd.wr2  = (state_r == S_WR2) && slot_free;
  end

  // phase sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        state_nxt = stat.skip_wr1 ? S_WR2 : S_WR1;
      end
      S_WR1: state_nxt = S_WR2;
      S_WR2: begin
        if (slot_free) state_nxt = in_valid ? S_RD1 : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cle_dp.sv
`default_nettype none

module cle_dp #(
  parameter int CAPACITY     = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cle_pkg::dp_cmd_t             cmd,
  output cle_pkg::dp_stat_t                 stat,
  input  wire cle_pkg::req_t                in_req,
  input  wire logic [cle_pkg::WORD_W-1:0]   in_word,
  input  wire logic                         in_rfs,
  output cle_pkg::res_t                     res
);

  localparam int NODE_W = $clog2(CAPACITY + 2);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [NODE_W-1:0] HEAD = NODE_W'(CAPACITY);
  localparam logic [NODE_W-1:0] TAIL = NODE_W'(CAPACITY + 1);

  // node pool memories
  logic [NODE_W-1:0]       fwd_mem [CAPACITY];
  logic [NODE_W-1:0]       bwd_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
  logic [IDX_W-1:0]        stk_mem [CAPACITY];

  logic [NODE_W-1:0]       fwd_rd_r;
  logic [NODE_W-1:0]       bwd_rd_r;
  logic [PAYLOAD_BITS-1:0] pay_rd_r;
  logic [IDX_W-1:0]        stk_rd_r;

  // item and list state
  cle_pkg::req_t           req_r, req_nxt;
  logic [PAYLOAD_BITS-1:0] word_r, word_nxt;
  logic                    rfs_r, rfs_nxt;
  logic [NODE_W-1:0]       cur_r, cur_nxt;
  logic [NODE_W-1:0]       rp_r, rp_nxt;
  logic [NODE_W-1:0]       head_next_r, head_next_nxt;
  logic [NODE_W-1:0]       a_r, a_nxt;
  logic [NODE_W-1:0]       b_r, b_nxt;
  logic [NODE_W-1:0]       g_r, g_nxt;
  logic [CNT_W-1:0]        fresh_r, fresh_nxt;
  logic [CNT_W-1:0]        rc_r, rc_nxt;

  // memory port controls
  logic              fwd_re, fwd_we, bwd_re, bwd_we, pay_re, pay_we, stk_re, stk_we;
  logic [IDX_W-1:0]  fwd_ra, fwd_wa, bwd_ra, bwd_wa, pay_ra, pay_wa, stk_ra, stk_wa;
  logic [NODE_W-1:0] fwd_wd, bwd_wd;
  logic [IDX_W-1:0]  stk_wd;

  // derived values
  logic              cur_head, full, ins_ok, removal, is_ins;
  logic [NODE_W-1:0] p0, a1, next1, alloc, lx, lv;
  logic [CNT_W-1:0]  rc_dec;

  always_comb begin
    cur_head = (cur_r == HEAD);
    p0       = rfs_r ? HEAD : rp_r;
    a1       = (req_r == cle_pkg::REQ_READ) ? p0 : cur_r;
    next1    = (a1 == HEAD) ? head_next_r : fwd_rd_r;
    full     = (rc_r == '0) && (fresh_r == CNT_W'(CAPACITY));
    alloc    = (rc_r != '0) ? NODE_W'(stk_rd_r) : NODE_W'(fresh_r);
    rc_dec   = rc_r - CNT_W'(1);
    is_ins   = (req_r == cle_pkg::REQ_INSERT);
    ins_ok   = is_ins && !full;
    removal  = ((req_r == cle_pkg::REQ_BACKSPACE) && !cur_head) ||
               ((req_r == cle_pkg::REQ_DELETE) && (g_r != TAIL));
    stat.skip_wr1 = !(is_ins || (req_r == cle_pkg::REQ_DELETE) ||
                      (req_r == cle_pkg::REQ_READ));
  end

  // read addresses per phase
  always_comb begin
    fwd_re = 1'b0;
    bwd_re = 1'b0;
    stk_re = 1'b0;
    pay_re = 1'b0;
    fwd_ra = a1[IDX_W-1:0];
    bwd_ra = cur_r[IDX_W-1:0];
    stk_ra = rc_dec[IDX_W-1:0];
    pay_ra = next1[IDX_W-1:0];
    if (cmd.rd1) begin
      unique case (req_r)
        cle_pkg::REQ_INSERT: begin
          fwd_re = 1'b1;
          stk_re = 1'b1;
        end
        cle_pkg::REQ_RIGHT:  fwd_re = 1'b1;
        cle_pkg::REQ_LEFT:   bwd_re = 1'b1;
        cle_pkg::REQ_BACKSPACE: begin
          fwd_re = 1'b1;
          bwd_re = 1'b1;
        end
        cle_pkg::REQ_DELETE: fwd_re = 1'b1;
        cle_pkg::REQ_READ:   fwd_re = 1'b1;
        default: ;
      endcase
    end
    // second hop follows the link fetched in the first
    if (cmd.rd2 && ((req_r == cle_pkg::REQ_DELETE) || (req_r == cle_pkg::REQ_READ))) begin
      fwd_re = 1'b1;
      fwd_ra = next1[IDX_W-1:0];
      pay_re = (req_r == cle_pkg::REQ_READ);
    end
  end

  // link writes, head sentinel kept in a register
  always_comb begin
    head_next_nxt = head_next_r;
    fwd_we = 1'b0;
    fwd_wa = a_r[IDX_W-1:0];
    fwd_wd = b_r;
    bwd_we = 1'b0;
    bwd_wa = a_r[IDX_W-1:0];
    bwd_wd = cur_r;
    pay_we = cmd.wr1 && ins_ok;
    pay_wa = a_r[IDX_W-1:0];
    stk_we = cmd.wr2 && removal;
    stk_wa = rc_r[IDX_W-1:0];
    stk_wd = g_r[IDX_W-1:0];
    lx     = ins_ok ? cur_r : a_r;
    lv     = ins_ok ? a_r : b_r;
    // new node gets its own links
    if (cmd.wr1 && ins_ok) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
    end
    // splice the neighbours, for insert and for removal alike
    if (cmd.wr2 && (ins_ok || removal)) begin
      if (lx == HEAD) begin
        head_next_nxt = lv;
      end else begin
        fwd_we = 1'b1;
        fwd_wa = lx[IDX_W-1:0];
        fwd_wd = lv;
      end
      bwd_we = (b_r != TAIL);
      bwd_wa = b_r[IDX_W-1:0];
      bwd_wd = a_r;
    end
  end

  // working registers and list state
  always_comb begin
    req_nxt   = req_r;
    word_nxt  = word_r;
    rfs_nxt   = rfs_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    g_nxt     = g_r;
    cur_nxt   = cur_r;
    rp_nxt    = rp_r;
    fresh_nxt = fresh_r;
    rc_nxt    = rc_r;
    // capture results of the first reads
    if (cmd.rd2) begin
      a_nxt = is_ins ? alloc : bwd_rd_r;
      b_nxt = next1;
      g_nxt = (req_r == cle_pkg::REQ_BACKSPACE) ? cur_r : next1;
    end
    // capture results of the second hop
    if (cmd.wr1) begin
      if (req_r == cle_pkg::REQ_DELETE) a_nxt = cur_r;
      if (!is_ins) b_nxt = fwd_rd_r;
    end
    // retire the item
    if (cmd.wr2) begin
      unique case (req_r)
        cle_pkg::REQ_INSERT: begin
          if (!full) begin
            cur_nxt = a_r;
            if (rc_r != '0) rc_nxt = rc_dec;
            else fresh_nxt = fresh_r + CNT_W'(1);
          end
        end
        cle_pkg::REQ_RIGHT: begin
          if (b_r != TAIL) cur_nxt = b_r;
        end
        cle_pkg::REQ_LEFT: begin
          if (!cur_head) cur_nxt = a_r;
        end
        cle_pkg::REQ_BACKSPACE: begin
          if (!cur_head) cur_nxt = a_r;
        end
        cle_pkg::REQ_READ: begin
          rp_nxt = (g_r != TAIL) ? g_r : p0;
        end
        default: ;
      endcase
      if (removal) begin
        rc_nxt = rc_r + CNT_W'(1);
        if (rp_r == g_r) rp_nxt = a_r;
      end
    end
    if (cmd.load) begin
      req_nxt  = in_req;
      word_nxt = in_word[PAYLOAD_BITS-1:0];
      rfs_nxt  = in_rfs;
    end
  end

  // result fields, valid in the retire phase
  always_comb begin
    res.read_word  = '0;
    res.read_valid = 1'b0;
    res.read_last  = 1'b0;
    unique case (req_r)
      cle_pkg::REQ_INSERT:    res.status = full ? cle_pkg::ST_FULL : cle_pkg::ST_DONE;
      cle_pkg::REQ_RIGHT:     res.status = (b_r == TAIL) ? cle_pkg::ST_EDGE : cle_pkg::ST_DONE;
      cle_pkg::REQ_LEFT:      res.status = cur_head ? cle_pkg::ST_EDGE : cle_pkg::ST_DONE;
      cle_pkg::REQ_BACKSPACE: res.status = cur_head ? cle_pkg::ST_EDGE : cle_pkg::ST_DONE;
      cle_pkg::REQ_DELETE:    res.status = (g_r == TAIL) ? cle_pkg::ST_EDGE : cle_pkg::ST_DONE;
      cle_pkg::REQ_READ: begin
        res.status = cle_pkg::ST_DONE;
        if (g_r != TAIL) begin
          res.read_word  = cle_pkg::WORD_W'(pay_rd_r);
          res.read_valid = 1'b1;
          res.read_last  = (b_r == TAIL);
        end
      end
      default: res.status = cle_pkg::ST_EDGE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (fwd_re) fwd_rd_r <= fwd_mem[fwd_ra];
  end

  always_ff @(posedge clk) begin
    if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
    if (bwd_re) bwd_rd_r <= bwd_mem[bwd_ra];
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_wa] <= word_r;
    if (pay_re) pay_rd_r <= pay_mem[pay_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_r <= stk_mem[stk_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    word_r <= word_nxt;
    rfs_r  <= rfs_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    g_r    <= g_nxt;
  end

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= HEAD;
      rp_r        <= HEAD;
      head_next_r <= TAIL;
      fresh_r     <= '0;
      rc_r        <= '0;
    end else begin
      cur_r       <= cur_nxt;
      rp_r        <= rp_nxt;
      head_next_r <= head_next_nxt;
      fresh_r     <= fresh_nxt;
      rc_r        <= rc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/cursor_list_editor.sv
// one item in flight: an item is taken when idle or in the retire phase of the last one, then
// passes rd1, rd2, wr1 and wr2 (wr1 only for insert, delete and read); retire waits for a free
// output register, and the phases follow the registered reads and writes on the link memories
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active low): empty list, cursor and read pointer on head, all pool nodes free;
//   link and payload memories are not cleared, so there is no clearing pass
`default_nettype none

module cursor_list_editor #(
  parameter int CAPACITY     = 1024,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // word[63:0]
  input  wire logic [3:0]  in_tuser,   // req_type[2:0], read_from_start[3]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // read_word[63:0]
  output logic [2:0]       out_tuser,  // status[1:0], read_valid[2]
  output logic             out_tlast   // read_last
);

  cle_pkg::dp_cmd_t  cmd;
  cle_pkg::dp_stat_t stat;
  cle_pkg::res_t     res;
  cle_pkg::res_t     out_res_r;
  logic              out_valid_r;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_tready;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .slot_free (slot_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  cle_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_req  (cle_pkg::req_t'(in_tuser[2:0])),
    .in_word (in_tdata),
    .in_rfs  (in_tuser[3]),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wr2) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr2) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.read_word;
  assign out_tuser  = {out_res_r.read_valid, out_res_r.status};
  assign out_tlast  = out_res_r.read_last;

  // one item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in flight");

  // last flag only on a returned word
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[2])
    else $error("read_last without read_valid");

  // a returned word always comes with done status
  a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == cle_pkg::ST_DONE))
    else $error("read word with non-done status");

  // no word data outside a returned word
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata == '0))
    else $error("word data without read_valid");

endmodule

`default_nettype wire
